// File: hdl/tnes_pkg.sv
// Package for the timed note event sequencer.
// Holds sizes, the note record, controller states and the command and status structs.
// Depends on nothing; tnes_ctrl, tnes_dp, the top level and the testbench use it.
package tnes_pkg;

    localparam int TABLE_DEPTH  = 256;
    localparam int ACTIVE_DEPTH = 16;
    localparam int PAYLOAD_BITS = 32;

    localparam int TABLE_AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int TABLE_CW  = $clog2(TABLE_DEPTH + 1);
    localparam int ACTIVE_AW = (ACTIVE_DEPTH > 1) ? $clog2(ACTIVE_DEPTH) : 1;
    localparam int ACTIVE_CW = $clog2(ACTIVE_DEPTH + 1);

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    typedef struct packed {
        logic [31:0]             start;
        logic [31:0]             length;
        logic [PAYLOAD_BITS-1:0] payload;
    } note_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_COMPACT,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic prep;
        logic compact_step;
        logic compact_end;
        logic scan_step;
        logic scan_end;
        logic emit_load;
    } cmd_t;

    typedef struct packed {
        logic step_req;
        logic same_tick;
        logic compact_done;
        logic scan_done;
        logic out_free;
        logic emit_last;
    } status_t;

endpackage

// File: hdl/tnes_if.sv
// Request channels of the timed note event sequencer: the item channel and the result channel.
// Depends on nothing.
interface tnes_item_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] note_start;
    logic [31:0] note_length;
    logic [31:0] note_payload;
    logic [31:0] now_tick;

    modport source (output valid, kind, note_start, note_length, note_payload, now_tick,
                    input ready);
    modport sink (input valid, kind, note_start, note_length, note_payload, now_tick,
                  output ready);
endinterface

interface tnes_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] active_payload;
    logic [31:0] active_start;
    logic [4:0]  active_total;
    logic        empty_set;
    logic        overflow;
    logic        last_of_run;

    modport source (output valid, active_payload, active_start, active_total, empty_set,
                    overflow, last_of_run, input ready);
    modport sink (input valid, active_payload, active_start, active_total, empty_set,
                  overflow, last_of_run, output ready);
endinterface

// File: hdl/tnes_ctrl.sv
// Controller state machine of the timed note event sequencer.
// Depends on tnes_pkg; drives commands to and reads status from tnes_dp.
module tnes_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  tnes_pkg::status_t status,
    output tnes_pkg::cmd_t    cmd
);

    tnes_pkg::state_t state_reg;
    tnes_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tnes_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tnes_pkg::ST_IDLE:
            begin
                if (status.step_req)
                begin
                    state_next = tnes_pkg::ST_PREP;
                end
            end
            tnes_pkg::ST_PREP:
            begin
                state_next = status.same_tick ? tnes_pkg::ST_EMIT : tnes_pkg::ST_COMPACT;
            end
            tnes_pkg::ST_COMPACT:
            begin
                if (status.compact_done)
                begin
                    state_next = tnes_pkg::ST_SCAN;
                end
            end
            tnes_pkg::ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = tnes_pkg::ST_EMIT;
                end
            end
            tnes_pkg::ST_EMIT:
            begin
                if (status.out_free && status.emit_last)
                begin
                    state_next = tnes_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tnes_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            tnes_pkg::ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
            end
            tnes_pkg::ST_PREP:
            begin
                cmd.prep = 1'b1;
            end
            tnes_pkg::ST_COMPACT:
            begin
                cmd.compact_step = !status.compact_done;
                cmd.compact_end  = status.compact_done;
            end
            tnes_pkg::ST_SCAN:
            begin
                cmd.scan_step = !status.scan_done;
                cmd.scan_end  = status.scan_done;
            end
            tnes_pkg::ST_EMIT:
            begin
                cmd.emit_load = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: hdl/tnes_dp.sv
// Datapath of the timed note event sequencer: note table memory, active set, counters
// and the result register. Depends on tnes_pkg and the channel interfaces in tnes_if.
module tnes_dp (
    input  logic              clk,
    input  logic              rst_n,
    tnes_item_if.sink         item,
    tnes_result_if.source     result,
    input  tnes_pkg::cmd_t    cmd,
    output tnes_pkg::status_t status
);

    localparam int TCW = tnes_pkg::TABLE_CW;
    localparam int TAW = tnes_pkg::TABLE_AW;
    localparam int ACW = tnes_pkg::ACTIVE_CW;
    localparam int AAW = tnes_pkg::ACTIVE_AW;

    tnes_pkg::note_t table_mem [tnes_pkg::TABLE_DEPTH];
    tnes_pkg::note_t table_rd_reg;
    tnes_pkg::note_t active_mem [tnes_pkg::ACTIVE_DEPTH];
    tnes_pkg::note_t act_rd;

    logic [TCW-1:0] table_count_reg;
    logic [TCW-1:0] scan_idx_reg;
    logic [TCW-1:0] scan_idx_next;
    logic           scan_skip_reg;
    logic [ACW-1:0] active_count_reg;
    logic [ACW-1:0] act_idx_reg;
    logic [ACW-1:0] kept_reg;
    logic [32:0]    prev_reg;
    logic [31:0]    now_reg;
    logic           ovf_reg;
    logic           out_valid_reg;

    logic [31:0] out_payload_reg;
    logic [31:0] out_start_reg;
    logic [4:0]  out_total_reg;
    logic        out_empty_reg;
    logic        out_ovf_reg;
    logic        out_last_reg;

    logic        accept;
    logic        load_we;
    logic        act_drop;
    logic [32:0] act_end;
    logic        le_prev;
    logic        skip_adv;
    logic        take;

    assign accept  = item.valid && cmd.in_ready;
    assign load_we = accept && (item.kind == tnes_pkg::KIND_LOAD)
                     && (table_count_reg < TCW'(tnes_pkg::TABLE_DEPTH));

    assign act_rd   = active_mem[act_idx_reg[AAW-1:0]];
    assign act_end  = {1'b0, act_rd.start} + {1'b0, act_rd.length};
    assign act_drop = (act_rd.start > now_reg) || (act_end < {1'b0, now_reg});

    assign le_prev  = !prev_reg[32] && (table_rd_reg.start <= prev_reg[31:0]);
    assign skip_adv = scan_skip_reg && le_prev;
    assign take     = table_rd_reg.start <= now_reg;

    always_comb
    begin
        scan_idx_next = scan_idx_reg;
        if (cmd.compact_end)
        begin
            scan_idx_next = '0;
        end
        else if (cmd.scan_step)
        begin
            scan_idx_next = scan_idx_reg + TCW'(1);
        end
    end

    always_comb
    begin
        status.step_req     = item.valid && (item.kind == tnes_pkg::KIND_STEP);
        status.same_tick    = prev_reg == {1'b0, now_reg};
        status.compact_done = act_idx_reg == active_count_reg;
        status.scan_done    = (scan_idx_reg == table_count_reg) || (!skip_adv && !take);
        status.out_free     = !out_valid_reg || result.ready;
        status.emit_last    = (active_count_reg == '0)
                              || (act_idx_reg + ACW'(1) == active_count_reg);
    end

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            table_mem[table_count_reg[TAW-1:0]] <= '{
                start:   item.note_start,
                length:  item.note_length,
                payload: item.note_payload[tnes_pkg::PAYLOAD_BITS-1:0]
            };
        end
        table_rd_reg <= table_mem[scan_idx_next[TAW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.compact_step && !act_drop)
        begin
            active_mem[kept_reg[AAW-1:0]] <= act_rd;
        end
        else if (cmd.scan_step && !skip_adv
                 && (active_count_reg < ACW'(tnes_pkg::ACTIVE_DEPTH)))
        begin
            active_mem[active_count_reg[AAW-1:0]] <= table_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (item.kind == tnes_pkg::KIND_STEP))
        begin
            now_reg <= item.now_tick;
        end
        if (cmd.emit_load)
        begin
            if (active_count_reg == '0)
            begin
                out_payload_reg <= '0;
                out_start_reg   <= '0;
                out_total_reg   <= '0;
                out_empty_reg   <= 1'b1;
            end
            else
            begin
                out_payload_reg <= 32'(act_rd.payload);
                out_start_reg   <= act_rd.start;
                out_total_reg   <= 5'(active_count_reg);
                out_empty_reg   <= 1'b0;
            end
            out_ovf_reg  <= ovf_reg;
            out_last_reg <= status.emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_count_reg  <= '0;
            scan_idx_reg     <= '0;
            scan_skip_reg    <= 1'b1;
            active_count_reg <= '0;
            act_idx_reg      <= '0;
            kept_reg         <= '0;
            prev_reg         <= '1;
            ovf_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            scan_idx_reg <= scan_idx_next;
            if (load_we)
            begin
                table_count_reg <= table_count_reg + TCW'(1);
            end
            if (cmd.prep)
            begin
                ovf_reg     <= 1'b0;
                act_idx_reg <= '0;
                kept_reg    <= '0;
                if ($signed(prev_reg) > $signed({1'b0, now_reg}))
                begin
                    prev_reg <= '1;
                end
            end
            if (cmd.compact_step)
            begin
                act_idx_reg <= act_idx_reg + ACW'(1);
                if (!act_drop)
                begin
                    kept_reg <= kept_reg + ACW'(1);
                end
            end
            if (cmd.compact_end)
            begin
                active_count_reg <= kept_reg;
                scan_skip_reg    <= 1'b1;
            end
            if (cmd.scan_step && !skip_adv)
            begin
                scan_skip_reg <= 1'b0;
                if (active_count_reg < ACW'(tnes_pkg::ACTIVE_DEPTH))
                begin
                    active_count_reg <= active_count_reg + ACW'(1);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.scan_end)
            begin
                prev_reg    <= {1'b0, now_reg};
                act_idx_reg <= '0;
            end
            if (cmd.emit_load)
            begin
                act_idx_reg   <= act_idx_reg + ACW'(1);
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign item.ready            = cmd.in_ready;
    assign result.valid          = out_valid_reg;
    assign result.active_payload = out_payload_reg;
    assign result.active_start   = out_start_reg;
    assign result.active_total   = out_total_reg;
    assign result.empty_set      = out_empty_reg;
    assign result.overflow       = out_ovf_reg;
    assign result.last_of_run    = out_last_reg;

`ifndef SYNTH
    a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_count_reg <= ACW'(tnes_pkg::ACTIVE_DEPTH))
        else $error("active set count exceeds its depth");

    a_table_bound: assert property (@(posedge clk) disable iff (!rst_n)
        table_count_reg <= TCW'(tnes_pkg::TABLE_DEPTH))
        else $error("note table count exceeds its depth");

    a_kept_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.compact_step |-> (kept_reg <= act_idx_reg))
        else $error("compaction write index passed its read index");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_load |=> out_valid_reg)
        else $error("loaded result not presented");
`endif

endmodule

// File: hdl/timed_note_event_sequencer.sv
// Top level of the timed note event sequencer.
// Depends on tnes_pkg, tnes_if, tnes_ctrl and tnes_dp.
//
// The item channel carries load requests (kind 0) and time step requests (kind 1).
// A load appends one note to the note table in the cycle it is accepted and gives no
// result; loads beyond the table depth are ignored. The table must be filled in
// ascending order of start tick.
// A time step drops expired or future notes from the active set, adds table notes whose
// start lies after the previous tick and at or before the current one, then sends one
// result request per active note, or a single empty marker, with last_of_run on the
// final one.
// A time step runs through PREP, COMPACT over the active notes held before the step,
// SCAN over the table entries and EMIT, which gives one result per cycle while the
// receiver takes them. The table scan reads the note memory once per cycle. A repeated
// tick skips both passes. Items are taken one at a time; a new request is accepted once
// the last result of the step sits in the output register.
// When the receiver stalls, the output register holds its result and the step waits.
// Reset empties the note table and the active set and forgets the previous tick.
module timed_note_event_sequencer (
    input  logic          clk,
    input  logic          rst_n,
    tnes_item_if.sink     item,
    tnes_result_if.source result
);

    tnes_pkg::cmd_t    cmd;
    tnes_pkg::status_t status;

    tnes_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    tnes_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cmd    (cmd),
        .status (status)
    );

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the timed note event sequencer.
// Sends load and time step requests, predicts the active notes of each step and checks
// every result request field by field; depends on tnes_pkg, tnes_if and the RTL top.
module tb_top;

    localparam int          RANDOM_ITEMS  = 40;
    localparam int          SETTLE_CYCLES = 400;
    localparam int          HOLD_CYCLES   = 600;
    localparam int          IDLE_PERCENT  = 23;
    localparam int          TIMEOUT_TICKS = 24_000_000;
    localparam logic [31:0] SONG_BASE     = 32'd2000;
    localparam logic [31:0] HIGH_BASE     = 32'hFFFF_FF00;
    localparam logic [31:0] ALL_ONES      = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] payload;
        logic [31:0] start;
        logic [4:0]  total;
        logic        empty_set;
        logic        overflow;
        logic        last_of_run;
    } voice_report_t;

    logic clk = 1'b0;
    logic rst_n;

    tnes_item_if   item_ch ();
    tnes_result_if result_ch ();

    timed_note_event_sequencer DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    tnes_pkg::note_t    song_table [tnes_pkg::TABLE_DEPTH];
    int                 song_count;
    tnes_pkg::note_t    sounding [tnes_pkg::ACTIVE_DEPTH];
    int                 sounding_count;
    logic signed [32:0] last_tick;
    voice_report_t      expected_voices [$];

    int          errors;
    bit          steady;
    bit          hold_off_pending;
    int          loads_sent;
    logic [31:0] cursor;
    logic [31:0] playhead;

    always #6 clk = ~clk;

    function automatic void record_note(input logic [31:0] at, input logic [31:0] len,
                                        input logic [31:0] pay);
        if (song_count < tnes_pkg::TABLE_DEPTH)
        begin
            song_table[song_count] = '{start: at, length: len,
                                       payload: pay[tnes_pkg::PAYLOAD_BITS-1:0]};
            song_count++;
        end
    endfunction

    function automatic void advance_to_tick(input logic [31:0] now);
        logic [32:0]   note_end;
        int            kept;
        int            idx;
        bit            dropped;
        voice_report_t report;
        dropped = 1'b0;
        if (last_tick != $signed({1'b0, now}))
        begin
            // Going back in time restarts the table scan from the first entry.
            if (last_tick > $signed({1'b0, now}))
                last_tick = -1;
            kept = 0;
            for (idx = 0; idx < sounding_count; idx++)
            begin
                note_end = {1'b0, sounding[idx].start} + {1'b0, sounding[idx].length};
                if (sounding[idx].start <= now && note_end >= {1'b0, now})
                begin
                    sounding[kept] = sounding[idx];
                    kept++;
                end
            end
            sounding_count = kept;
            idx = 0;
            while (idx < song_count && $signed({1'b0, song_table[idx].start}) <= last_tick)
                idx++;
            while (idx < song_count && song_table[idx].start <= now)
            begin
                if (sounding_count < tnes_pkg::ACTIVE_DEPTH)
                begin
                    sounding[sounding_count] = song_table[idx];
                    sounding_count++;
                end
                else
                    dropped = 1'b1;
                idx++;
            end
            last_tick = $signed({1'b0, now});
        end
        if (sounding_count == 0)
        begin
            report = '{payload: '0, start: '0, total: '0, empty_set: 1'b1,
                       overflow: dropped, last_of_run: 1'b1};
            expected_voices.push_back(report);
        end
        else
            for (idx = 0; idx < sounding_count; idx++)
            begin
                report.payload     = 32'(sounding[idx].payload);
                report.start       = sounding[idx].start;
                report.total       = 5'(sounding_count);
                report.empty_set   = 1'b0;
                report.overflow    = dropped;
                report.last_of_run = (idx == sounding_count - 1);
                expected_voices.push_back(report);
            end
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin : scoreboard
        voice_report_t want;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_voices.size() == 0)
                begin
                    $error("Result with no request pending: payload %0h, start %0h",
                           result_ch.active_payload, result_ch.active_start);
                    errors++;
                end
                else
                begin
                    want = expected_voices.pop_front();
                    compare_field("active_payload", want.payload, result_ch.active_payload);
                    compare_field("active_start", want.start, result_ch.active_start);
                    compare_field("active_total", 32'(want.total), 32'(result_ch.active_total));
                    compare_field("empty_set", 32'(want.empty_set), 32'(result_ch.empty_set));
                    compare_field("overflow", 32'(want.overflow), 32'(result_ch.overflow));
                    compare_field("last_of_run", 32'(want.last_of_run),
                                  32'(result_ch.last_of_run));
                end
            end
            if (item_ch.valid && item_ch.ready)
            begin
                if (item_ch.kind == tnes_pkg::KIND_LOAD)
                    record_note(item_ch.note_start, item_ch.note_length, item_ch.note_payload);
                else
                    advance_to_tick(item_ch.now_tick);
            end
        end
    end

    initial
    begin : result_sink
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_pending)
            begin
                hold_off_pending = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                result_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    initial
    begin : watchdog
        #(TIMEOUT_TICKS);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_item(input logic kind, input logic [31:0] at, input logic [31:0] len,
                             input logic [31:0] pay, input logic [31:0] now);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.kind         <= kind;
        item_ch.note_start   <= at;
        item_ch.note_length  <= len;
        item_ch.note_payload <= pay;
        item_ch.now_tick     <= now;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
    endtask

    task automatic load_note(input logic [31:0] at, input logic [31:0] len,
                             input logic [31:0] pay);
        send_item(tnes_pkg::KIND_LOAD, at, len, pay, $urandom());
        loads_sent++;
    endtask

    task automatic step_to(input logic [31:0] now);
        send_item(tnes_pkg::KIND_STEP, $urandom(), $urandom(), $urandom(), now);
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_voices.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_empty_steps();
        step_to(32'd0);
        step_to(32'd0);
        step_to(ALL_ONES);
        step_to(32'd7);
        wait_drained();
    endtask

    task automatic test_note_extremes();
        load_note(32'd0, 32'd0, 32'd0);
        load_note(32'd0, ALL_ONES, ALL_ONES);
        load_note(32'd3, 32'd2, 32'hA5A5_A5A5);
        load_note(32'd5, 32'd0, 32'h5A5A_5A5A);
        load_note(32'd9, 32'd1, $urandom());
        step_to(32'd0);
        step_to(32'd0);
        step_to(32'd1);
        step_to(32'd5);
        step_to(32'd6);
        step_to(32'd9);
        step_to(32'd10);
        step_to(32'd11);
        wait_drained();
    endtask

    task automatic test_active_overflow();
        int k;
        for (k = 0; k < 6; k++)
            load_note(32'd40, 32'd1000, $urandom());
        step_to(32'd40);
        step_to(32'd41);
        // The restart adds every table note again on top of the ones still sounding.
        step_to(32'd40);
        wait_drained();
    endtask

    task automatic test_random_song();
        int          counted;
        int          burst;
        int          k;
        int          pick;
        logic [31:0] at;
        logic [31:0] len;
        logic [31:0] now;
        counted  = 0;
        cursor   = SONG_BASE;
        playhead = SONG_BASE;
        while (counted < RANDOM_ITEMS)
        begin
            steady = (counted >= 10 && counted < 30);
            burst = $urandom_range(6, 1);
            for (k = 0; k < burst; k++)
            begin
                pick = $urandom_range(99);
                if (pick < 5)
                    at = cursor - $urandom_range(300);
                else if (pick < 8)
                    at = cursor + 400;
                else
                begin
                    cursor = cursor + $urandom_range(20);
                    at = cursor;
                end
                pick = $urandom_range(99);
                if (pick < 4)
                    len = ALL_ONES;
                else if (pick < 8)
                    len = $urandom();
                else if (pick < 15)
                    len = 32'd0;
                else
                    len = $urandom_range(150);
                if (loads_sent < tnes_pkg::TABLE_DEPTH)
                    counted++;
                load_note(at, len, $urandom());
            end
            burst = $urandom_range(6, 1);
            for (k = 0; k < burst; k++)
            begin
                pick = $urandom_range(99);
                if (pick < 8)
                    now = playhead;
                else if (pick < 14)
                begin
                    playhead = playhead - $urandom_range(100);
                    now = playhead;
                end
                else if (pick < 18)
                begin
                    playhead = $urandom_range(playhead);
                    now = playhead;
                end
                else if (pick < 22)
                    now = $urandom();
                else
                begin
                    if (cursor > playhead + 200)
                        playhead = cursor - $urandom_range(100);
                    else
                        playhead = playhead + $urandom_range(30);
                    now = playhead;
                end
                step_to(now);
                counted++;
            end
        end
        steady = 1'b0;
        wait_drained();
    endtask

    task automatic test_receiver_hold();
        int k;
        hold_off_pending = 1'b1;
        for (k = 0; k < 4; k++)
        begin
            cursor = cursor + 3;
            load_note(cursor, 32'd500, $urandom());
        end
        for (k = 0; k < 5; k++)
        begin
            playhead = cursor + k;
            step_to(playhead);
        end
        wait_drained();
    endtask

    task automatic test_table_full();
        int          idx;
        int          k;
        logic [31:0] at;
        logic [31:0] len;
        logic [31:0] pay;
        idx = 0;
        while (loads_sent < tnes_pkg::TABLE_DEPTH + 3)
        begin
            if (loads_sent == tnes_pkg::TABLE_DEPTH - 1)
            begin
                at  = ALL_ONES;
                len = ALL_ONES;
                pay = ALL_ONES;
            end
            else
            begin
                at  = (loads_sent >= tnes_pkg::TABLE_DEPTH) ? $urandom()
                                                            : HIGH_BASE + 32'(idx);
                len = $urandom_range(40);
                pay = $urandom();
            end
            load_note(at, len, pay);
            idx++;
        end
        step_to(32'hFFFF_FF40);
        step_to(ALL_ONES);
        step_to(ALL_ONES);
        step_to(32'd2500);
        step_to(32'hFFFF_FFFE);
        step_to(ALL_ONES);
        step_to(32'd0);
        step_to(32'd0);
        for (k = 0; k < 10; k++)
        begin
            if (k % 3 == 0)
                step_to($urandom());
            else if (k % 3 == 1)
                step_to(HIGH_BASE + $urandom_range(255));
            else
                step_to(SONG_BASE + $urandom_range(cursor - SONG_BASE));
        end
        wait_drained();
    endtask

    initial
    begin : stimulus
        errors           = 0;
        steady           = 1'b0;
        hold_off_pending = 1'b0;
        loads_sent       = 0;
        song_count       = 0;
        sounding_count   = 0;
        last_tick        = -1;
        rst_n                <= 1'b0;
        item_ch.valid        <= 1'b0;
        item_ch.kind         <= tnes_pkg::KIND_LOAD;
        item_ch.note_start   <= '0;
        item_ch.note_length  <= '0;
        item_ch.note_payload <= '0;
        item_ch.now_tick     <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_steps();
        test_note_extremes();
        test_active_overflow();
        test_random_song();
        test_receiver_hold();
        test_table_full();
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: filelist.f
hdl/tnes_pkg.sv
hdl/tnes_if.sv
hdl/tnes_ctrl.sv
hdl/tnes_dp.sv
hdl/timed_note_event_sequencer.sv
dv/tb_top.sv
